FILE: design/bda_pkg.sv
// shared types and constants for the binary to decimal ascii converter
`default_nettype none
package bda_pkg;

  localparam int NumDigits  = 5;
  localparam int QueueDepth = 4;

  // reciprocal constants for division by 100 and by 10
  localparam logic [16:0] Recip100Wide   = 17'd83887; // 2^23 / 100, rounded up
  localparam logic [5:0]  Recip100Narrow = 6'd41;     // 2^12 / 100, rounded up
  localparam logic [7:0]  Recip10        = 8'd205;    // 2^11 / 10, rounded up

  localparam logic [6:0] Hundred   = 7'd100;
  localparam logic [3:0] Ten       = 4'd10;
  localparam logic [5:0] AsciiZero = 6'd48;

  // digit position codes
  localparam logic [2:0] PosTenThousands = 3'd0;
  localparam logic [2:0] PosThousands    = 3'd1;
  localparam logic [2:0] PosHundreds     = 3'd2;
  localparam logic [2:0] PosTens         = 3'd3;
  localparam logic [2:0] PosOnes         = 3'd4;

  typedef struct packed {
    logic        func;
    logic [15:0] value;
  } req_t;

  typedef struct packed {
    logic [5:0] character;
    logic       last;
  } rsp_t;

  // one converted number: five bcd digits and the first position to send
  typedef struct packed {
    logic [NumDigits-1:0][3:0] digits;
    logic [2:0]                start;
  } entry_t;

endpackage
`default_nettype wire

FILE: design/bda_front.sv
// front pipeline: splits the number into bcd digits and finds the first one to send
`default_nettype none
module bda_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire bda_pkg::req_t req,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bda_pkg::entry_t    out_entry
);
  import bda_pkg::*;

  // stage valid bits and enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  // stage 1 payload
  logic        s1_func;
  logic [15:0] s1_val;
  logic [9:0]  s1_hi;
  // stage 2 payload
  logic        s2_func;
  logic [9:0]  s2_hi;
  logic [6:0]  s2_lo;
  logic [2:0]  s2_hh;
  // stage 3 payload
  logic        s3_func;
  logic [2:0]  s3_hh;
  logic [6:0]  s3_mid;
  logic [6:0]  s3_lo;
  logic [3:0]  s3_lo_t;
  // stage 4 payload
  logic        s4_func;
  logic [2:0]  s4_hh;
  logic [6:0]  s4_mid;
  logic [3:0]  s4_mid_t;
  logic [3:0]  s4_lo_t;
  logic [3:0]  s4_lo_o;

  logic [15:0] val_in;
  logic [32:0] prod_hi;
  logic [15:0] prod_hh;
  logic [14:0] prod_lo_t;
  logic [14:0] prod_mid_t;
  logic [3:0]  mid_o;

  // stall chain from the queue back to the request port
  assign en4       = !v4 || out_ready;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign req_ready = en1;
  assign out_valid = v4;

  // mode 0 only looks at the low byte
  assign val_in  = req.func ? req.value : {8'd0, req.value[7:0]};
  assign prod_hi = val_in * Recip100Wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= req_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1: value / 100
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_func <= req.func;
      s1_val  <= val_in;
      s1_hi   <= prod_hi[32:23];
    end
  end

  // stage 2: value % 100 and hundreds / 100
  assign prod_hh = s1_hi * Recip100Narrow;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_func <= s1_func;
      s2_hi   <= s1_hi;
      s2_lo   <= 7'(s1_val - 16'(s1_hi) * 16'(Hundred));
      s2_hh   <= prod_hh[14:12];
    end
  end

  // stage 3: middle pair and tens of the low pair
  assign prod_lo_t = s2_lo * Recip10;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_func <= s2_func;
      s3_hh   <= s2_hh;
      s3_mid  <= 7'(s2_hi - 10'(s2_hh) * 10'(Hundred));
      s3_lo   <= s2_lo;
      s3_lo_t <= prod_lo_t[14:11];
    end
  end

  // stage 4: tens of the middle pair and ones of the low pair
  assign prod_mid_t = s3_mid * Recip10;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_func  <= s3_func;
      s4_hh    <= s3_hh;
      s4_mid   <= s3_mid;
      s4_mid_t <= prod_mid_t[14:11];
      s4_lo_t  <= s3_lo_t;
      s4_lo_o  <= 4'(s3_lo - 7'(s3_lo_t) * 7'(Ten));
    end
  end

  // hundreds digit and classification toward the queue
  assign mid_o = 4'(s4_mid - 7'(s4_mid_t) * 7'(Ten));

  always_comb begin
    out_entry.digits[PosTenThousands] = {1'b0, s4_hh};
    out_entry.digits[PosThousands]    = s4_mid_t;
    out_entry.digits[PosHundreds]     = mid_o;
    out_entry.digits[PosTens]         = s4_lo_t;
    out_entry.digits[PosOnes]         = s4_lo_o;
    if (!s4_func) begin
      out_entry.start = PosHundreds;
    end else if (s4_hh != 3'd0) begin
      out_entry.start = PosTenThousands;
    end else if (s4_mid_t != 4'd0) begin
      out_entry.start = PosThousands;
    end else if (mid_o != 4'd0) begin
      out_entry.start = PosHundreds;
    end else if (s4_lo_t != 4'd0) begin
      out_entry.start = PosTens;
    end else begin
      out_entry.start = PosOnes;
    end
  end

endmodule
`default_nettype wire

FILE: design/bda_queue.sv
// short queue between the front pipeline and the character sender
`default_nettype none
module bda_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire bda_pkg::entry_t push_entry,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output bda_pkg::entry_t      pop_entry
);
  import bda_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  entry_t            mem [QueueDepth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [PtrW:0]     count;
  logic              push;
  logic              pop;

  assign push_ready = (count != (PtrW+1)'(QueueDepth));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/bda_back.sv
// back end: queued digits to the output register, one char per cycle unless stalled
`default_nettype none
module bda_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            head_valid,
  input  wire bda_pkg::entry_t head,
  output logic                 pop,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output bda_pkg::rsp_t        rsp
);
  import bda_pkg::*;

  logic       started;
  logic [2:0] idx;
  logic [2:0] cur_idx;
  logic       emit;
  logic       at_last;
  logic [3:0] digit;

  // position of the digit to send from the head entry
  assign cur_idx = started ? idx : head.start;
  assign emit    = head_valid && (!rsp_valid || rsp_ready);
  assign at_last = (cur_idx == PosOnes);
  assign pop     = emit && at_last;

  always_comb begin
    case (cur_idx)
      PosTenThousands: digit = head.digits[PosTenThousands];
      PosThousands:    digit = head.digits[PosThousands];
      PosHundreds:     digit = head.digits[PosHundreds];
      PosTens:         digit = head.digits[PosTens];
      default:         digit = head.digits[PosOnes];
    endcase
  end

  // digit position within the current number
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      idx     <= '0;
    end else if (emit) begin
      started <= !at_last;
      idx     <= cur_idx + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.character <= AsciiZero + {2'b00, digit};
      rsp.last      <= at_last;
    end
  end

endmodule
`default_nettype wire

FILE: design/binary_to_decimal_ascii.sv
// top level of the binary to decimal ascii converter
//
//  channel | signals                     | carries
//  --------+-----------------------------+--------------------------------------
//  request | req_valid, req_ready, req   | func (mode), value (number to format)
//  result  | rsp_valid, rsp_ready, rsp   | character ('0'..'9'), last (final digit)
//
// one character leaves per cycle while the result channel is ready and the queue
// holds a number: a number gives 3 characters in mode 0 and 1 to 5 in mode 1.
// after a request is accepted, its first character passes the 4 pipeline stages
// in the front, the queue, then the output register.
// a request is taken every cycle while the 4-entry queue and pipeline have room,
// so a stalled result channel holds the front off only once they fill.
// reset is synchronous and clears only valid bits, queue pointers, counts and the
// digit position of the sender.
`default_nettype none
module binary_to_decimal_ascii (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire bda_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output bda_pkg::rsp_t      rsp
);
  import bda_pkg::*;

  logic   front_valid;
  logic   front_ready;
  entry_t front_entry;
  logic   head_valid;
  entry_t head;
  logic   pop;

  // digit extraction and classification
  bda_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_entry (front_entry)
  );

  // decoupling queue
  bda_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_entry (front_entry),
    .pop_valid  (head_valid),
    .pop_ready  (pop),
    .pop_entry  (head)
  );

  // character sender
  bda_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

endmodule
`default_nettype wire

FILE: tb/tb_binary_to_decimal_ascii.sv
// testbench for the binary to decimal ascii converter: directed table plus random numbers
`timescale 1ns / 1ps
module tb_binary_to_decimal_ascii;
  import bda_pkg::*;

  // mode codes of the request
  localparam logic FuncByte = 1'b0;
  localparam logic FuncWord = 1'b1;

  localparam int NumRandom  = 450;
  localparam int CycleLimit = 1000000;
  localparam int MaxReports = 10;

  // one directed row: request plus an optional typed-in digit string
  typedef struct packed {
    logic        func;
    logic [15:0] value;
    logic [2:0]  typed_len;
    logic [39:0] typed;
  } row_t;

  localparam int NumRows = 24;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_ready;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_ready = 1'b0;
  rsp_t  rsp;

  rsp_t  expected_chars[$];
  row_t  dir_rows[NumRows];
  int    mismatches = 0;
  int    cycles = 0;
  int    ready_hold = 0;
  int    burst_left = 0;

  binary_to_decimal_ascii DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("binary_to_decimal_ascii: mismatch");
      $finish;
    end
  end

  // idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // expected characters of one request, most significant digit first
  function automatic void predict_chars(req_t r);
    int unsigned n;
    int unsigned div;
    int unsigned d;
    logic [3:0]  digs[$];
    bit          started;
    rsp_t        c;
    if (r.func == FuncByte) begin
      n = 32'(r.value[7:0]);
      div = 100;
      started = 1'b1;
    end else begin
      n = 32'(r.value);
      div = 10000;
      started = 1'b0;
    end
    while (div >= 1) begin
      d = (n / div) % 10;
      if (started || d != 0 || div == 1) begin
        digs.push_back(d[3:0]);
        started = 1'b1;
      end
      div = div / 10;
    end
    foreach (digs[i]) begin
      c.character = AsciiZero + {2'b00, digs[i]};
      c.last = (i == digs.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  // expected characters read straight off a typed-in string
  function automatic void push_typed(row_t row);
    rsp_t c;
    logic [7:0] ch;
    for (int k = 0; k < row.typed_len; k++) begin
      ch = row.typed[8 * (row.typed_len - 1 - k) +: 8];
      c.character = ch[5:0];
      c.last = (k == row.typed_len - 1);
      expected_chars.push_back(c);
    end
  endfunction

  // random request: spread over digit counts, upper bits noise in byte mode
  function automatic req_t random_request();
    req_t r;
    int   pick;
    r.func = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    case (pick)
      0: r.value = 16'($urandom_range(0, 9));
      1: r.value = 16'($urandom_range(10, 99));
      2: r.value = 16'($urandom_range(100, 999));
      3: r.value = 16'($urandom_range(1000, 9999));
      4: r.value = 16'($urandom_range(10000, 65535));
      5: r.value = {8'h00, 8'($urandom_range(0, 255))};
      6: r.value = 16'($urandom_range(65500, 65535));
      default: r.value = 16'($urandom());
    endcase
    return r;
  endfunction

  // mismatch log, first few only
  task automatic note_mismatch(string what, rsp_t want, rsp_t got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%s: expected char %0d last %0b, got char %0d last %0b",
               what, want.character, want.last, got.character, got.last);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_chars.size() == 0) begin
        note_mismatch("unexpected result", '0, rsp);
      end else begin
        want = expected_chars.pop_front();
        if (rsp.character !== want.character || rsp.last !== want.last) begin
          note_mismatch("wrong result", want, rsp);
        end
      end
    end
  end

  // result side stalls, with stretches of steady ready
  always @(negedge clk) begin
    int r;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        rsp_ready <= 1'b1;
        ready_hold <= $urandom_range(20, 60);
      end else if (r < 65) begin
        rsp_ready <= 1'b1;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        rsp_ready <= 1'b0;
        ready_hold <= pick_gap();
      end
    end
  end

  // request driver
  initial begin
    req_t r;
    int   gap;
    int   total;

    // directed table: extremes typed in, the rest predicted
    dir_rows[0]  = '{FuncByte, 16'd0,     3'd3, "000"};
    dir_rows[1]  = '{FuncByte, 16'd255,   3'd3, "255"};
    dir_rows[2]  = '{FuncByte, 16'hFF00,  3'd3, "000"};
    dir_rows[3]  = '{FuncByte, 16'hFFFF,  3'd3, "255"};
    dir_rows[4]  = '{FuncWord, 16'd0,     3'd1, "0"};
    dir_rows[5]  = '{FuncWord, 16'd65535, 3'd5, "65535"};
    dir_rows[6]  = '{FuncByte, 16'd100,   3'd0, 40'd0};
    dir_rows[7]  = '{FuncByte, 16'd9,     3'd0, 40'd0};
    dir_rows[8]  = '{FuncByte, 16'd10,    3'd0, 40'd0};
    dir_rows[9]  = '{FuncByte, 16'd99,    3'd0, 40'd0};
    dir_rows[10] = '{FuncByte, 16'hAB7B,  3'd0, 40'd0};
    dir_rows[11] = '{FuncByte, 16'd128,   3'd0, 40'd0};
    dir_rows[12] = '{FuncWord, 16'd9,     3'd0, 40'd0};
    dir_rows[13] = '{FuncWord, 16'd10,    3'd0, 40'd0};
    dir_rows[14] = '{FuncWord, 16'd99,    3'd0, 40'd0};
    dir_rows[15] = '{FuncWord, 16'd100,   3'd0, 40'd0};
    dir_rows[16] = '{FuncWord, 16'd999,   3'd0, 40'd0};
    dir_rows[17] = '{FuncWord, 16'd1000,  3'd0, 40'd0};
    dir_rows[18] = '{FuncWord, 16'd9999,  3'd0, 40'd0};
    dir_rows[19] = '{FuncWord, 16'd10000, 3'd0, 40'd0};
    dir_rows[20] = '{FuncWord, 16'd10001, 3'd0, 40'd0};
    dir_rows[21] = '{FuncWord, 16'd50000, 3'd0, 40'd0};
    dir_rows[22] = '{FuncWord, 16'h8000,  3'd0, 40'd0};
    dir_rows[23] = '{FuncWord, 16'd1,     3'd0, 40'd0};

    // reset
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    total = NumRows + NumRandom;
    for (int i = 0; i < total; i++) begin
      if (i < NumRows) begin
        r.func  = dir_rows[i].func;
        r.value = dir_rows[i].value;
      end else begin
        r = random_request();
      end

      // idle before this request, or keep valid high in a burst
      if (burst_left > 0) begin
        burst_left--;
        gap = 0;
      end else begin
        gap = pick_gap();
        if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 30);
      end
      if (gap > 0) begin
        req_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      req = r;
      req_valid = 1'b1;

      // hold until accepted
      do @(posedge clk); while (!req_ready);
      if (i < NumRows && dir_rows[i].typed_len != 0) begin
        push_typed(dir_rows[i]);
      end else begin
        predict_chars(r);
      end
      @(negedge clk);
    end
    req_valid = 1'b0;

    // drain, then watch for stray results
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_chars.size() != 0) mismatches += expected_chars.size();

    if (mismatches == 0) begin
      $display("binary_to_decimal_ascii: match");
    end else begin
      $display("binary_to_decimal_ascii: mismatch");
    end
    $finish;
  end

endmodule
